// ----- hdl/instruction_prefetch_queue_top_macros.svh -----
// Assertion shorthands, clocked on clk and disabled while rst_n is low
`ifndef INSTRUCTION_PREFETCH_QUEUE_TOP_MACROS_SVH
`define INSTRUCTION_PREFETCH_QUEUE_TOP_MACROS_SVH

`define IPQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`define IPQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/ipq_pkg.sv -----
`default_nettype none
package ipq_pkg;

  localparam int MAX_QUEUE_BYTES = 32;
  localparam int QIDX_W          = $clog2(MAX_QUEUE_BYTES);
  localparam int QV_W            = MAX_QUEUE_BYTES * 8;
  localparam int QS_W            = 6;
  localparam int ADDR_W          = 32;
  localparam int SIZE_W          = 3;

  localparam logic [QS_W-1:0] QS_RESET = 6'd16;
  localparam logic [QS_W-1:0] QS_MIN   = 6'd8;
  localparam logic [QS_W-1:0] QS_MAX   = QS_W'(MAX_QUEUE_BYTES);
  localparam logic [QS_W-1:0] QS_TAIL  = 6'd4;

  localparam logic [SIZE_W-1:0] SZ_BYTE  = 3'd1;
  localparam logic [SIZE_W-1:0] SZ_WORD  = 3'd2;
  localparam logic [SIZE_W-1:0] SZ_DWORD = 3'd4;

  typedef enum logic [1:0] {
    CMD_FETCH = 2'd0,
    CMD_FILL  = 2'd1,
    CMD_INVAL = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [1:0]        command;
    logic [ADDR_W-1:0] fetch_address;
    logic [SIZE_W-1:0] fetch_size;
    logic [7:0]        fill_byte;
  } in_word_t;

  typedef struct packed {
    logic              data_valid;
    logic [31:0]       fetched_value;
    logic              fill_request;
    logic [ADDR_W-1:0] fill_address;
    logic [QS_W-1:0]   fill_count;
    logic              busy_error;
  } out_word_t;

endpackage
`default_nettype wire

// ----- hdl/ipq_if.sv -----
`default_nettype none
interface ipq_in_if
  import ipq_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic [ADDR_W-1:0] fetch_address;
  logic [SIZE_W-1:0] fetch_size;
  logic [7:0]        fill_byte;

  modport source (output valid, command, fetch_address, fetch_size, fill_byte, input ready);
  modport sink   (input valid, command, fetch_address, fetch_size, fill_byte, output ready);
endinterface

interface ipq_out_if
  import ipq_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              data_valid;
  logic [31:0]       fetched_value;
  logic              fill_request;
  logic [ADDR_W-1:0] fill_address;
  logic [QS_W-1:0]   fill_count;
  logic              busy_error;

  modport source (output valid, data_valid, fetched_value, fill_request, fill_address,
                  fill_count, busy_error, input ready);
  modport sink   (input valid, data_valid, fetched_value, fill_request, fill_address,
                  fill_count, busy_error, output ready);
endinterface
`default_nettype wire

// ----- hdl/instruction_prefetch_queue_top.sv -----
// A word accepted is held in the input register s1_r, worked on combinationally, and its
// result is registered in the output register out_r, from which it is presented.
// Throughput: one word per cycle; the input register stalls only while the output is held.
// Reset (rst_n low, synchronous): queue invalid, no fill pending, window at 0, size 16.
// Queue byte contents are not reset.
`default_nettype none
`include "instruction_prefetch_queue_top_macros.svh"
module instruction_prefetch_queue_top
  import ipq_pkg::*;
(
  input  wire              clk,
  input  wire              rst_n,
  ipq_in_if.sink           in_ch,
  ipq_out_if.source        out_ch,
  input  wire              cfg_we,
  input  wire [QS_W-1:0]   cfg_wdata
);

  function automatic logic [31:0] size_mask(input logic [SIZE_W-1:0] sz,
                                            input logic [31:0] v);
    case (sz)
      SZ_BYTE: return {24'b0, v[7:0]};
      SZ_WORD: return {16'b0, v[15:0]};
      default: return v;
    endcase
  endfunction

  // input stage
  logic      s1_valid_r, s1_valid_nxt;
  in_word_t  s1_r;
  logic      s1_adv;
  logic      in_acc;

  // queue state
  logic [QS_W-1:0]   qs_r, qs_nxt, qs_act;
  logic [7:0]        q_r   [MAX_QUEUE_BYTES];
  logic [7:0]        q_nxt [MAX_QUEUE_BYTES];
  logic [ADDR_W-1:0] win_r, win_nxt;
  logic              qvalid_r, qvalid_nxt;
  logic [QS_W-1:0]   fpos_r, fpos_nxt;
  logic              pend_r, pend_nxt;
  logic [SIZE_W-1:0] dsize_r, dsize_nxt;

  // output stage
  logic      out_valid_r, out_valid_nxt;
  out_word_t out_r;
  out_word_t res;
  logic      res_valid;

  // datapath
  logic [QV_W-1:0]   qvec, gvec, svec;
  logic [ADDR_W-1:0] off, win_shift;
  logic [QS_W-1:0]   size6, next, rest;
  logic              size_ok, hit, shift_go;

  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_comb begin
    if (qs_r < QS_MIN) begin
      qs_act = QS_MIN;
    end else if (qs_r > QS_MAX) begin
      qs_act = QS_MAX;
    end else begin
      qs_act = qs_r;
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_QUEUE_BYTES; i++) begin
      qvec[i*8 +: 8] = q_r[i];
    end
    size6     = {{(QS_W-SIZE_W){1'b0}}, s1_r.fetch_size};
    size_ok   = (s1_r.fetch_size == SZ_BYTE) || (s1_r.fetch_size == SZ_WORD) ||
                (s1_r.fetch_size == SZ_DWORD);
    off       = s1_r.fetch_address - win_r;
    if (s1_r.fetch_size == SZ_BYTE) begin
      hit = qvalid_r && (off < {{(ADDR_W-QS_W){1'b0}}, qs_act});
    end else begin
      hit = qvalid_r && (off < {{(ADDR_W-QS_W){1'b0}}, qs_act - size6});
    end
    gvec      = qvec >> {off[QIDX_W-1:0], 3'b000};
    svec      = gvec >> {s1_r.fetch_size, 3'b000};
    next      = off[QS_W-1:0] + size6;
    rest      = qs_act - next;
    shift_go  = (next >= qs_act - QS_TAIL) && (next < qs_act);
    win_shift = s1_r.fetch_address + {{(ADDR_W-SIZE_W){1'b0}}, s1_r.fetch_size};
  end

  always_comb begin
    q_nxt      = q_r;
    win_nxt    = win_r;
    qvalid_nxt = qvalid_r;
    fpos_nxt   = fpos_r;
    pend_nxt   = pend_r;
    dsize_nxt  = dsize_r;
    res_valid  = 1'b0;
    res        = '0;
    if (s1_adv) begin
      case (s1_r.command)
        CMD_FETCH: begin
          if (size_ok) begin
            res_valid = 1'b1;
            if (pend_r) begin
              res.busy_error = 1'b1;
            end else if (hit) begin
              res.data_valid    = 1'b1;
              res.fetched_value = size_mask(s1_r.fetch_size, gvec[31:0]);
              if (shift_go) begin
                for (int i = 0; i < MAX_QUEUE_BYTES; i++) begin
                  if (QS_W'(i) < rest) begin
                    q_nxt[i] = svec[i*8 +: 8];
                  end
                end
                win_nxt          = win_shift;
                fpos_nxt         = rest;
                pend_nxt         = 1'b1;
                dsize_nxt        = '0;
                res.fill_request = 1'b1;
                res.fill_address = win_shift + {{(ADDR_W-QS_W){1'b0}}, rest};
                res.fill_count   = next;
              end
            end else begin
              win_nxt          = s1_r.fetch_address;
              qvalid_nxt       = 1'b0;
              fpos_nxt         = '0;
              pend_nxt         = 1'b1;
              dsize_nxt        = s1_r.fetch_size;
              res.fill_request = 1'b1;
              res.fill_address = s1_r.fetch_address;
              res.fill_count   = qs_act;
            end
          end
        end
        CMD_FILL: begin
          if (pend_r) begin
            if (fpos_r < QS_MAX) begin
              q_nxt[fpos_r[QIDX_W-1:0]] = s1_r.fill_byte;
            end
            fpos_nxt = fpos_r + QS_W'(1);
            if (fpos_nxt >= qs_act) begin
              pend_nxt   = 1'b0;
              qvalid_nxt = 1'b1;
              if (dsize_r != '0) begin
                res_valid         = 1'b1;
                res.data_valid    = 1'b1;
                res.fetched_value = size_mask(dsize_r, {q_nxt[3], q_nxt[2], q_nxt[1], q_nxt[0]});
                dsize_nxt         = '0;
              end
            end
          end
        end
        CMD_INVAL: begin
          qvalid_nxt = 1'b0;
          pend_nxt   = 1'b0;
          dsize_nxt  = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    qs_nxt = cfg_we ? cfg_wdata : qs_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
    if (s1_adv) begin
      out_valid_nxt = res_valid;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      qs_r        <= QS_RESET;
      win_r       <= '0;
      qvalid_r    <= 1'b0;
      fpos_r      <= '0;
      pend_r      <= 1'b0;
      dsize_r     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      qs_r        <= qs_nxt;
      win_r       <= win_nxt;
      qvalid_r    <= qvalid_nxt;
      fpos_r      <= fpos_nxt;
      pend_r      <= pend_nxt;
      dsize_r     <= dsize_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    if (in_acc) begin
      s1_r.command       <= in_ch.command;
      s1_r.fetch_address <= in_ch.fetch_address;
      s1_r.fetch_size    <= in_ch.fetch_size;
      s1_r.fill_byte     <= in_ch.fill_byte;
    end
    if (s1_adv) begin
      out_r <= res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.data_valid    = out_r.data_valid;
  assign out_ch.fetched_value = out_r.fetched_value;
  assign out_ch.fill_request  = out_r.fill_request;
  assign out_ch.fill_address  = out_r.fill_address;
  assign out_ch.fill_count    = out_r.fill_count;
  assign out_ch.busy_error    = out_r.busy_error;

  `IPQ_ASSERT_IMP(a_defer_pend, dsize_r != '0, pend_r, "waiting fetch without a fill")
  `IPQ_ASSERT_IMP(a_fpos_range, 1'b1, fpos_r <= QS_MAX, "fill position past queue end")
  `IPQ_ASSERT_IMP(a_busy_alone, out_valid_r && out_r.busy_error,
                  !out_r.data_valid && !out_r.fill_request, "busy word carries data")
  `IPQ_ASSERT_NXT(a_s1_hold, s1_valid_r && !s1_adv, s1_valid_r && $stable(s1_r),
                  "stalled input word lost")

endmodule
`default_nettype wire
